// ===== sv/rsti_pkg.sv =====
// rsti_pkg: shared widths, register indexes, character codes and the digit match type
// for the radix string to integer block; no dependencies
package rsti_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned SYMBOLS = 16;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned SYMBOLS_W = SYMBOLS * SYM_W;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam int unsigned MAX_BASE_DEFAULT = 16;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH = 2'd2;

  // character codes
  localparam logic [SYM_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [SYM_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [SYM_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_PLUS = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  // result of matching one byte against the alphabet
  typedef struct packed {
    logic                hit;
    logic [DIGIT_W-1:0]  index;
  } digit_t;

  function automatic logic is_space(input logic [SYM_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_sign(input logic [SYM_W-1:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

endpackage

// ===== sv/rsti_base_check.sv =====
// rsti_base_check: registered validity check of the configured digit alphabet
// depends on rsti_pkg
module rsti_base_check #(
  parameter int unsigned MAX_BASE = rsti_pkg::MAX_BASE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rsti_pkg::SYMBOLS_W-1:0] symbols,
  input  logic [rsti_pkg::LEN_W-1:0]     length,
  output logic                           base_ok
);

  logic length_ok;
  logic bad_symbol;
  logic duplicate;
  logic base_ok_next;

  assign length_ok = (length >= rsti_pkg::LEN_W'(2)) &&
                     (length <= rsti_pkg::LEN_W'(MAX_BASE));

  always_comb begin
    logic [rsti_pkg::SYM_W-1:0] c;
    bad_symbol = 1'b0;
    duplicate = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      c = symbols[i*rsti_pkg::SYM_W +: rsti_pkg::SYM_W];
      if (rsti_pkg::LEN_W'(i) < length) begin
        if ((c == rsti_pkg::CHAR_NUL) || rsti_pkg::is_sign(c) || rsti_pkg::is_space(c)) begin
          bad_symbol = 1'b1;
        end
      end
      for (int j = i + 1; j < MAX_BASE; j++) begin
        // symbol j in use implies symbol i in use
        if ((rsti_pkg::LEN_W'(j) < length) &&
            (symbols[j*rsti_pkg::SYM_W +: rsti_pkg::SYM_W] == c)) begin
          duplicate = 1'b1;
        end
      end
    end
  end

  assign base_ok_next = length_ok && !bad_symbol && !duplicate;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ok <= 1'b0;
    end else begin
      base_ok <= base_ok_next;
    end
  end

endmodule

// ===== sv/rsti_digit_decode.sv =====
// rsti_digit_decode: parallel compare of one byte against the digit alphabet
// depends on rsti_pkg
module rsti_digit_decode #(
  parameter int unsigned MAX_BASE = rsti_pkg::MAX_BASE_DEFAULT
) (
  input  logic [rsti_pkg::SYMBOLS_W-1:0] symbols,
  input  logic [rsti_pkg::LEN_W-1:0]     length,
  input  logic                           base_ok,
  input  logic [rsti_pkg::SYM_W-1:0]     symbol,
  output rsti_pkg::digit_t               digit
);

  always_comb begin
    digit.hit = 1'b0;
    digit.index = '0;
    // walk downward so the lowest matching lane wins
    for (int k = MAX_BASE - 1; k >= 0; k--) begin
      if ((rsti_pkg::LEN_W'(k) < length) &&
          (symbols[k*rsti_pkg::SYM_W +: rsti_pkg::SYM_W] == symbol)) begin
        digit.hit = base_ok;
        digit.index = rsti_pkg::DIGIT_W'(k);
      end
    end
  end

endmodule

// ===== sv/radix_string_to_integer.sv =====
// radix_string_to_integer: top level, parses a byte stream as a signed number in a
// configured digit alphabet; depends on rsti_pkg, rsti_base_check, rsti_digit_decode
//
//   channel   direction  handshake              word
//   in        sink       in_valid / in_stall    symbol, end_of_string
//   out       source     out_valid / out_stall  value, base_ok
//   cfg       sink       cfg_we                 cfg_index, cfg_data
//
// one word per cycle sustained unless an end-of-string word waits; a word is parsed
// from the input register (digit compare, one small multiply-add, optional negate)
// a result is loaded into the output register at the edge after its end-of-string
// word is accepted, or later while a stalled result still holds that register
// the alphabet check is registered and settles after the config registers take a write
// rst is synchronous: parse state, valids and config registers clear
// a stalled result holds; input stalls only when an end-of-string word waits on it
module radix_string_to_integer #(
  parameter int unsigned MAX_BASE = rsti_pkg::MAX_BASE_DEFAULT,
  parameter int unsigned VALUE_WIDTH = rsti_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rsti_pkg::SYM_W-1:0]       symbol,
  input  logic                             end_of_string,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [VALUE_WIDTH-1:0]    value,
  output logic                             base_ok,
  // configuration
  input  logic                             cfg_we,
  input  logic [rsti_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsti_pkg::CFG_W-1:0]       cfg_data
);

  // parse phase codes
  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration registers
  logic [rsti_pkg::CFG_W-1:0] base_symbols_low;
  logic [rsti_pkg::CFG_W-1:0] base_symbols_high;
  logic [rsti_pkg::LEN_W-1:0] base_length;
  logic [rsti_pkg::SYMBOLS_W-1:0] symbols;
  logic alphabet_ok;

  // input register
  logic                       q_valid;
  logic [rsti_pkg::SYM_W-1:0] q_symbol;
  logic                       q_eos;

  // parse state
  logic [1:0]             phase;
  logic [1:0]             phase_next;
  logic                   negative;
  logic                   negative_next;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;

  rsti_pkg::digit_t digit;
  logic take_digit;
  logic [VALUE_WIDTH+rsti_pkg::LEN_W-1:0] product;
  logic [VALUE_WIDTH-1:0] result_value;

  logic in_accept;
  logic out_free;
  logic proc_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_symbols_low <= '0;
      base_symbols_high <= '0;
      base_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsti_pkg::REG_SYMBOLS_LOW: base_symbols_low <= cfg_data;
        rsti_pkg::REG_SYMBOLS_HIGH: base_symbols_high <= cfg_data;
        rsti_pkg::REG_BASE_LENGTH: base_length <= cfg_data[rsti_pkg::LEN_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign symbols = {base_symbols_high, base_symbols_low};

  rsti_base_check #(
    .MAX_BASE(MAX_BASE)
  ) u_base_check (
    .clk    (clk),
    .rst    (rst),
    .symbols(symbols),
    .length (base_length),
    .base_ok(alphabet_ok)
  );

  rsti_digit_decode #(
    .MAX_BASE(MAX_BASE)
  ) u_digit_decode (
    .symbols(symbols),
    .length (base_length),
    .base_ok(alphabet_ok),
    .symbol (q_symbol),
    .digit  (digit)
  );

  // handshake: a word without end of string never waits on the output side
  assign out_free = !out_valid || !out_stall;
  assign proc_go = q_valid && (!q_eos || out_free);
  assign in_stall = q_valid && !proc_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_accept) begin
      q_valid <= 1'b1;
    end else if (proc_go) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_symbol <= symbol;
      q_eos <= end_of_string;
    end
  end

  // parse step: skip whitespace, then signs, then digits; anything else ends the number
  always_comb begin
    phase_next = phase;
    negative_next = negative;
    take_digit = 1'b0;
    priority if (phase == PH_DONE) begin
      phase_next = PH_DONE;
    end else if ((phase == PH_SPACE) && rsti_pkg::is_space(q_symbol)) begin
      phase_next = PH_SPACE;
    end else if ((phase != PH_DIGIT) && rsti_pkg::is_sign(q_symbol)) begin
      // each minus flips the sign
      negative_next = negative ^ (q_symbol == rsti_pkg::CHAR_MINUS);
      phase_next = PH_SIGN;
    end else if (digit.hit) begin
      take_digit = 1'b1;
      phase_next = PH_DIGIT;
    end else begin
      phase_next = PH_DONE;
    end
  end

  // value * radix + digit, wrapped to the value width
  assign product = acc * base_length;
  assign acc_next = take_digit ?
                    (product[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit.index)) : acc;

  always_comb begin
    if (!alphabet_ok) begin
      result_value = '0;
    end else if (negative_next) begin
      result_value = VALUE_WIDTH'(0) - acc_next;
    end else begin
      result_value = acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      negative <= 1'b0;
      acc <= '0;
    end else if (proc_go) begin
      if (q_eos) begin
        // string ends: fresh parse for the next one
        phase <= PH_SPACE;
        negative <= 1'b0;
        acc <= '0;
      end else begin
        phase <= phase_next;
        negative <= negative_next;
        acc <= acc_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_go && q_eos) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && q_eos) begin
      value <= result_value;
      base_ok <= alphabet_ok;
    end
  end

  // a new result is only loaded from an end-of-string word
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc_go && q_eos))
    else $error("result appeared without an end-of-string word");

  // a rejected alphabet always gives a zero value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !base_ok) |-> (value == '0))
    else $error("nonzero value with invalid alphabet");

  // input back-pressure only comes from a waiting end-of-string word
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_valid && q_eos && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // parse state is fresh after each string
  assert property (@(posedge clk) disable iff (rst)
    (proc_go && q_eos) |=> ((phase == PH_SPACE) && !negative && (acc == '0)))
    else $error("parse state not cleared after end of string");

endmodule

// ===== sim/rsti_checker.sv =====
// rsti_checker: watches the word channels of radix_string_to_integer, predicts every
// result from its own copy of the alphabet and parse state, and compares; uses rsti_pkg
module rsti_checker #(
  parameter int unsigned MAX_BASE = rsti_pkg::MAX_BASE_DEFAULT,
  parameter int unsigned VALUE_WIDTH = rsti_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [rsti_pkg::SYM_W-1:0]       symbol,
  input  logic                             end_of_string,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [VALUE_WIDTH-1:0]    value,
  input  logic                             base_ok,
  input  logic                             cfg_we,
  input  logic [rsti_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsti_pkg::CFG_W-1:0]       cfg_data,
  output int                               mismatches,
  output int                               results_owed,
  output int                               results_checked,
  output int                               rejected_results
);
  import rsti_pkg::*;

  typedef enum logic [1:0] {SKIP_BLANKS, TAKE_SIGNS, TAKE_DIGITS, FINISHED} scan_phase_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          base_ok;
  } parsed_t;

  logic [CFG_W-1:0]       digits_low;
  logic [CFG_W-1:0]       digits_high;
  logic [LEN_W-1:0]       radix;
  scan_phase_e            phase;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] acc;
  parsed_t                parsed_q[$];

  function automatic logic [SYM_W-1:0] alpha_at(input int k);
    if (k < 8) return digits_low[SYM_W*k +: SYM_W];
    return digits_high[SYM_W*(k-8) +: SYM_W];
  endfunction

  function automatic logic is_blank(input logic [SYM_W-1:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic alphabet_ok();
    int n;
    logic [SYM_W-1:0] c;
    n = radix;
    if (n < 2 || n > MAX_BASE || n > SYMBOLS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = alpha_at(i);
      if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || is_blank(c)) return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (alpha_at(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_index(input logic [SYM_W-1:0] c);
    for (int k = 0; k < SYMBOLS; k++)
      if (k < radix && alpha_at(k) == c) return k;
    return -1;
  endfunction

  task automatic take_char(input logic [SYM_W-1:0] c, input logic last);
    logic    ok;
    int      d;
    parsed_t r;
    ok = alphabet_ok();
    d = ok ? digit_index(c) : -1;
    // leading blanks and everything after the number are dropped
    if (phase == FINISHED || (phase == SKIP_BLANKS && is_blank(c))) begin
    end else if (phase != TAKE_DIGITS && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      if (c == CHAR_MINUS) negative = !negative;
      phase = TAKE_SIGNS;
    end else if (d >= 0) begin
      acc = acc * VALUE_WIDTH'(radix) + VALUE_WIDTH'(d);
      phase = TAKE_DIGITS;
    end else begin
      phase = FINISHED;
    end
    if (last) begin
      r.value = ok ? (negative ? -acc : acc) : '0;
      r.base_ok = ok;
      parsed_q.push_back(r);
      phase = SKIP_BLANKS;
      negative = 1'b0;
      acc = '0;
    end
  endtask

  task automatic check_result();
    parsed_t want;
    if (parsed_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual value %0d base_ok %0b",
               $time, value, base_ok);
      return;
    end
    want = parsed_q.pop_front();
    results_checked++;
    if (!want.base_ok) rejected_results++;
    if (value !== want.value) begin
      mismatches++;
      $display("%0t: value expected %0d actual %0d", $time, $signed(want.value), value);
    end
    if (base_ok !== want.base_ok) begin
      mismatches++;
      $display("%0t: base_ok expected %0b actual %0b", $time, want.base_ok, base_ok);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      digits_low = '0;
      digits_high = '0;
      radix = '0;
      phase = SKIP_BLANKS;
      negative = 1'b0;
      acc = '0;
      parsed_q.delete();
      mismatches = 0;
      results_owed = 0;
      results_checked = 0;
      rejected_results = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_SYMBOLS_LOW: digits_low = cfg_data;
          REG_SYMBOLS_HIGH: digits_high = cfg_data;
          REG_BASE_LENGTH: radix = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_char(symbol, end_of_string);
      results_owed = parsed_q.size();
    end
  end

endmodule

// ===== sim/tb_radix_string_to_integer.sv =====
// tb_radix_string_to_integer: drives strings and alphabet settings into the parser and
// gives the verdict; uses rsti_pkg, radix_string_to_integer and rsti_checker
module tb_radix_string_to_integer;
  import rsti_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH_DEFAULT;
  // length of the one long output hold-off that backs the block up
  localparam int HOLD_CYCLES = 150;

  // ways to spoil an otherwise good alphabet
  typedef enum int {
    FLAW_REPEAT, FLAW_SIGN, FLAW_BLANK, FLAW_NUL, FLAW_TOO_SHORT, FLAW_ALL_ONES
  } flaw_e;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic [SYM_W-1:0]       symbol = '0;
  logic                   end_of_string = 1'b0;
  logic                   out_stall = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  wire                    in_stall;
  wire                    out_valid;
  wire signed [VW-1:0]    value;
  wire                    base_ok;

  int mismatches;
  int results_owed;
  int results_checked;
  int rejected_results;

  // alphabet as the stimulus knows it, and the string being sent
  logic [SYM_W-1:0] alpha [SYMBOLS];
  int               alpha_len;
  logic [SYM_W-1:0] text [$];

  int burst_left;
  int chars_sent;
  int alphabets_used;
  bit squeeze_req;

  radix_string_to_integer dut (.*);

  rsti_checker #(.VALUE_WIDTH(VW)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [SYM_W-1:0] pick_blank();
    if ($urandom_range(0, 5) == 0) return CHAR_SPACE;
    return SYM_W'($urandom_range(CHAR_TAB, CHAR_CR));
  endfunction

  function automatic logic [SYM_W-1:0] pick_sign();
    return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
  endfunction

  // a byte that is fine as a digit symbol: low control codes or anything above '-'
  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 7) == 0) return SYM_W'($urandom_range(1, 8));
    return SYM_W'($urandom_range(CHAR_MINUS + 1, 8'hFF));
  endfunction

  // digits come from the alphabet even when it is rejected
  function automatic logic [SYM_W-1:0] pick_digit();
    return alpha[$urandom_range(0, (alpha_len > 1 ? alpha_len : 2) - 1)];
  endfunction

  task automatic make_alphabet(input int n);
    logic [SYM_W-1:0] c;
    bit clash;
    alpha_len = n;
    for (int i = 0; i < SYMBOLS; i++) begin
      if (i >= n) begin
        // unused slots may hold zero bytes or repeats, the block must not care
        alpha[i] = ($urandom_range(0, 3) == 0) ? CHAR_NUL : SYM_W'($urandom);
      end else begin
        do begin
          c = pick_symbol();
          clash = 1'b0;
          for (int j = 0; j < i; j++)
            if (alpha[j] == c) clash = 1'b1;
        end while (clash);
        alpha[i] = c;
      end
    end
  endtask

  task automatic spoil_alphabet(input flaw_e flaw);
    int i;
    int j;
    make_alphabet($urandom_range(2, SYMBOLS));
    i = $urandom_range(0, alpha_len - 1);
    case (flaw)
      FLAW_REPEAT: begin
        j = (i + $urandom_range(1, alpha_len - 1)) % alpha_len;
        alpha[j] = alpha[i];
      end
      FLAW_SIGN: alpha[i] = pick_sign();
      FLAW_BLANK: alpha[i] = pick_blank();
      FLAW_NUL: alpha[i] = CHAR_NUL;
      FLAW_TOO_SHORT: alpha_len = $urandom_range(0, 1);
      FLAW_ALL_ONES: begin
        alpha_len = SYMBOLS;
        foreach (alpha[k]) alpha[k] = 8'hFF;
      end
      default: ;
    endcase
  endtask

  // three back-to-back register writes, then a wait for the alphabet check to settle
  task automatic load_alphabet();
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    for (int k = 0; k < 8; k++) begin
      lo[SYM_W*k +: SYM_W] = alpha[k];
      hi[SYM_W*k +: SYM_W] = alpha[k+8];
    end
    cfg_we <= 1'b1;
    cfg_index <= REG_SYMBOLS_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_SYMBOLS_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_BASE_LENGTH;
    cfg_data <= CFG_W'(alpha_len);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
    alphabets_used++;
  endtask

  // offer one word; bursts of random length with random gaps, some long unbroken runs
  task automatic push_char(input logic [SYM_W-1:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    symbol <= c;
    end_of_string <= last;
    // stall is steady between edges, so look at it on the falling edge before
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) push_char(text[i], i == text.size() - 1);
  endtask

  task automatic set_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  // mostly well-formed numbers with random content, some broken ones and some noise
  task automatic random_string();
    int kind;
    text.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(SYM_W'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
      repeat ($urandom_range(0, 3)) text.push_back(pick_sign());
      // blank right after the signs ends the number when at least one sign came before it
      if (kind == 1) text.push_back(pick_blank());
      repeat ($urandom_range(0, 12)) text.push_back(pick_digit());
      // sign after the digits ends the number when at least one digit came before it
      if (kind == 2) text.push_back(pick_sign());
      repeat ($urandom_range(0, 2))
        text.push_back($urandom_range(0, 1) ? pick_digit() : SYM_W'($urandom));
    end
    if (text.size() == 0) text.push_back(pick_digit());
  endtask

  // drop valid, wait for every result, then let the pipeline empty out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_strings(input int budget);
    int goal;
    goal = chars_sent + budget;
    while (chars_sent < goal) begin
      random_string();
      send_text();
    end
    drain();
  endtask

  // receiver: stall density changes over spans of random length, plus one long hold-off
  initial begin : receiver
    int pct;
    int span_left;
    int hold_left;
    pct = 0;
    span_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end
      if (span_left == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 85;
        endcase
        span_left = $urandom_range(16, 64);
      end
      span_left--;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // registers still at reset: length zero, every result must be zero
    alpha_len = 0;
    foreach (alpha[k]) alpha[k] = CHAR_NUL;
    alphabets_used = 1;
    run_strings(12);

    // plain decimal digits
    foreach (alpha[k]) alpha[k] = SYM_W'(8'h30 + k);
    alpha_len = 10;
    load_alphabet();
    // every blank, then a sign run that cancels, a digit, an all-ones byte ending it
    text = '{CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, CHAR_SPACE,
             CHAR_MINUS, CHAR_PLUS, CHAR_MINUS, 8'h39, 8'hFF, 8'h37};
    send_text();
    // blank after a sign is not skipped
    set_text("- 5");
    send_text();
    // zero byte ends the number before it starts
    text = '{CHAR_NUL, 8'h31};
    send_text();
    // wraps past the most negative value to the most positive one
    set_text("-2147483649");
    send_text();
    run_strings(50);

    // widest alphabet; the receiver holds off for a while so the block fills up
    make_alphabet(SYMBOLS);
    load_alphabet();
    squeeze_req = 1'b1;
    run_strings(110);

    // narrowest alphabet
    make_alphabet(2);
    load_alphabet();
    run_strings(60);

    make_alphabet($urandom_range(3, SYMBOLS - 1));
    load_alphabet();
    run_strings(70);

    // each kind of rejected alphabet
    for (int f = FLAW_REPEAT; f <= FLAW_ALL_ONES; f++) begin
      spoil_alphabet(flaw_e'(f));
      load_alphabet();
      run_strings(25);
    end

    // extreme symbol bytes: all-ones down and the lowest legal code
    for (int k = 0; k < SYMBOLS - 1; k++) alpha[k] = SYM_W'(8'hFF - k);
    alpha[SYMBOLS-1] = 8'h01;
    alpha_len = SYMBOLS;
    load_alphabet();
    run_strings(60);

    $display("covered %0d characters under %0d alphabet settings, good and rejected",
             chars_sent, alphabets_used);
    $display("compared %0d results, %0d of them from rejected alphabets",
             results_checked, rejected_results);
    if (mismatches == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rsti_pkg.sv
sv/rsti_base_check.sv
sv/rsti_digit_decode.sv
sv/radix_string_to_integer.sv
sim/rsti_checker.sv
sim/tb_radix_string_to_integer.sv
